/* src/stl_pkg.sv */
// ----------------------------------------------------------------------------
// stl_pkg: shared types and tables for the source token lexer
// Holds token kind codes, scanner modes, the queue entry format and the
// reserved-word tables used to narrow the keyword candidate mask.
// ----------------------------------------------------------------------------
package stl_pkg;

  localparam int unsigned MAX_IDENT_LEN_DEF = 255;
  localparam int unsigned QUEUE_DEPTH_DEF   = 4;
  localparam int unsigned NUM_KW            = 24;

  typedef logic [5:0] token_kind_t;

  localparam token_kind_t TK_NEWLINE  = 6'd0;
  localparam token_kind_t TK_EOF      = 6'd1;
  localparam token_kind_t TK_GT       = 6'd2;
  localparam token_kind_t TK_GE       = 6'd3;
  localparam token_kind_t TK_LT       = 6'd4;
  localparam token_kind_t TK_LE       = 6'd5;
  localparam token_kind_t TK_EQ       = 6'd6;
  localparam token_kind_t TK_NE       = 6'd7;
  localparam token_kind_t TK_SLASH    = 6'd8;
  localparam token_kind_t TK_LBRACKET = 6'd9;
  localparam token_kind_t TK_RBRACKET = 6'd10;
  localparam token_kind_t TK_LPAREN   = 6'd11;
  localparam token_kind_t TK_RPAREN   = 6'd12;
  localparam token_kind_t TK_PLUS     = 6'd13;
  localparam token_kind_t TK_MINUS    = 6'd14;
  localparam token_kind_t TK_STAR     = 6'd15;
  localparam token_kind_t TK_PERCENT  = 6'd16;
  localparam token_kind_t TK_COMMA    = 6'd17;
  localparam token_kind_t TK_COLON    = 6'd18;
  localparam token_kind_t TK_ASSIGN   = 6'd19;
  localparam token_kind_t TK_KEYWORD0 = 6'd20;
  localparam token_kind_t TK_REAL     = 6'd44;
  localparam token_kind_t TK_INTEGER  = 6'd45;
  localparam token_kind_t TK_IDENT    = 6'd46;
  localparam token_kind_t TK_RANGE    = 6'd47;
  localparam token_kind_t TK_DOT      = 6'd48;
  localparam token_kind_t TK_ERROR    = 6'd49;
  localparam token_kind_t TK_UNKNOWN  = 6'd50;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_OP      = 4'd1,
    MODE_INT     = 4'd2,
    MODE_INT_DOT = 4'd3,
    MODE_REAL    = 4'd4,
    MODE_IDENT   = 4'd5,
    MODE_DOT     = 4'd6
  } scan_mode_t;

  typedef enum logic [1:0] {
    PEND_GT    = 2'd0,
    PEND_LT    = 2'd1,
    PEND_SLASH = 2'd2,
    PEND_COLON = 2'd3
  } pend_op_t;

  // One queue entry carries every token that a single input beat produced.
  typedef struct packed {
    logic        two;
    token_kind_t first;
    token_kind_t second;
  } tok_pair_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) || (b == "_");
  endfunction

  // Reserved words, padded to eight characters; character 0 is the top byte.
  function automatic logic [63:0] kw_word(input logic [4:0] k);
    logic [63:0] w;
    unique case (k)
      5'd0:    w = "and     ";
      5'd1:    w = "or      ";
      5'd2:    w = "xor     ";
      5'd3:    w = "if      ";
      5'd4:    w = "then    ";
      5'd5:    w = "else    ";
      5'd6:    w = "true    ";
      5'd7:    w = "false   ";
      5'd8:    w = "var     ";
      5'd9:    w = "type    ";
      5'd10:   w = "routine ";
      5'd11:   w = "return  ";
      5'd12:   w = "is      ";
      5'd13:   w = "in      ";
      5'd14:   w = "reverse ";
      5'd15:   w = "for     ";
      5'd16:   w = "while   ";
      5'd17:   w = "loop    ";
      5'd18:   w = "end     ";
      5'd19:   w = "record  ";
      5'd20:   w = "array   ";
      5'd21:   w = "integer ";
      5'd22:   w = "real    ";
      5'd23:   w = "boolean ";
      default: w = 64'h0;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] kw_len(input logic [4:0] k);
    logic [3:0] n;
    unique case (k)
      5'd0, 5'd2, 5'd8, 5'd15, 5'd18:                n = 4'd3;
      5'd1, 5'd3, 5'd12, 5'd13:                      n = 4'd2;
      5'd4, 5'd5, 5'd6, 5'd9, 5'd17, 5'd22:          n = 4'd4;
      5'd7, 5'd16, 5'd20:                            n = 4'd5;
      5'd11, 5'd19:                                  n = 4'd6;
      5'd10, 5'd14, 5'd21, 5'd23:                    n = 4'd7;
      default:                                       n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] kw_char(input logic [4:0] k, input logic [2:0] pos);
    logic [63:0] w;
    w = kw_word(k);
    return w[63 - 8 * int'(pos) -: 8];
  endfunction

  // Narrow the candidate mask with the character at position pos.
  function automatic logic [NUM_KW-1:0] kw_step(input logic [NUM_KW-1:0] cand,
                                                input logic [7:0] pos,
                                                input logic [7:0] b);
    logic [NUM_KW-1:0] r;
    for (int k = 0; k < NUM_KW; k++) begin
      r[k] = cand[k] && (pos < {4'd0, kw_len(5'(k))}) && (kw_char(5'(k), pos[2:0]) == b);
    end
    return r;
  endfunction

  function automatic token_kind_t ident_kind(input logic [NUM_KW-1:0] cand,
                                             input logic [7:0] len);
    token_kind_t r;
    r = TK_IDENT;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (cand[k] && (len == {4'd0, kw_len(5'(k))})) begin
        r = TK_KEYWORD0 + 6'(k);
      end
    end
    return r;
  endfunction

  function automatic token_kind_t op_single(input pend_op_t p);
    token_kind_t r;
    unique case (p)
      PEND_GT:    r = TK_GT;
      PEND_LT:    r = TK_LT;
      PEND_SLASH: r = TK_SLASH;
      PEND_COLON: r = TK_COLON;
      default:    r = TK_GT;
    endcase
    return r;
  endfunction

  function automatic token_kind_t op_double(input pend_op_t p);
    token_kind_t r;
    unique case (p)
      PEND_GT:    r = TK_GE;
      PEND_LT:    r = TK_LE;
      PEND_SLASH: r = TK_NE;
      PEND_COLON: r = TK_ASSIGN;
      default:    r = TK_GE;
    endcase
    return r;
  endfunction

endpackage

/* src/stl_front.sv */
// ----------------------------------------------------------------------------
// stl_front: byte scanner
// Updates the scanner mode, keyword mask and identifier length for each
// accepted beat and produces the zero, one or two tokens that beat causes.
// ----------------------------------------------------------------------------
module stl_front #(
  parameter int unsigned MAX_IDENT_LEN = stl_pkg::MAX_IDENT_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        text_byte,
  input  logic              end_of_text,
  output logic              push,
  output stl_pkg::tok_pair_t push_data
);
  import stl_pkg::*;

  scan_mode_t        mode, mode_next;
  logic [NUM_KW-1:0] cand, cand_next;
  logic [7:0]        ilen, ilen_next;
  pend_op_t          pend, pend_next;

  logic        idle_emit, idle_pend_we, idle_ident;
  token_kind_t idle_kind;
  scan_mode_t  idle_mode;
  pend_op_t    idle_pend;

  logic        em_a, em_b, reproc;
  token_kind_t kind_a, kind_b;
  logic        is_dig, is_let, is_dotc;

  assign is_dig  = !end_of_text && is_digit(text_byte);
  assign is_let  = !end_of_text && is_letter(text_byte);
  assign is_dotc = !end_of_text && (text_byte == ".");

  // Classification of a byte seen from the idle mode.
  always_comb begin
    idle_emit    = 1'b1;
    idle_kind    = TK_UNKNOWN;
    idle_mode    = MODE_IDLE;
    idle_pend_we = 1'b0;
    idle_pend    = PEND_GT;
    idle_ident   = 1'b0;
    if (end_of_text) begin
      idle_kind = TK_EOF;
    end else begin
      unique case (text_byte)
        " ", "\t": idle_emit = 1'b0;
        "\n":      idle_kind = TK_NEWLINE;
        "[":       idle_kind = TK_LBRACKET;
        "]":       idle_kind = TK_RBRACKET;
        "(":       idle_kind = TK_LPAREN;
        ")":       idle_kind = TK_RPAREN;
        "=":       idle_kind = TK_EQ;
        "+":       idle_kind = TK_PLUS;
        "-":       idle_kind = TK_MINUS;
        "*":       idle_kind = TK_STAR;
        "%":       idle_kind = TK_PERCENT;
        ",":       idle_kind = TK_COMMA;
        ">": begin
          idle_emit = 1'b0; idle_mode = MODE_OP; idle_pend_we = 1'b1; idle_pend = PEND_GT;
        end
        "<": begin
          idle_emit = 1'b0; idle_mode = MODE_OP; idle_pend_we = 1'b1; idle_pend = PEND_LT;
        end
        "/": begin
          idle_emit = 1'b0; idle_mode = MODE_OP; idle_pend_we = 1'b1; idle_pend = PEND_SLASH;
        end
        ":": begin
          idle_emit = 1'b0; idle_mode = MODE_OP; idle_pend_we = 1'b1; idle_pend = PEND_COLON;
        end
        ".": begin
          idle_emit = 1'b0; idle_mode = MODE_DOT;
        end
        default: begin
          if (is_digit(text_byte)) begin
            idle_emit = 1'b0;
            idle_mode = MODE_INT;
          end else if (is_letter(text_byte)) begin
            idle_emit  = 1'b0;
            idle_mode  = MODE_IDENT;
            idle_ident = 1'b1;
          end
        end
      endcase
    end
  end

  // Mode-specific handling; a byte that ends a token is reprocessed as idle.
  always_comb begin
    mode_next = mode;
    cand_next = cand;
    ilen_next = ilen;
    pend_next = pend;
    em_a      = 1'b0;
    kind_a    = TK_NEWLINE;
    em_b      = 1'b0;
    kind_b    = TK_NEWLINE;
    reproc    = 1'b0;
    unique case (mode)
      MODE_OP: begin
        em_a = 1'b1;
        if (!end_of_text && (text_byte == "=")) begin
          kind_a    = op_double(pend);
          mode_next = MODE_IDLE;
        end else begin
          kind_a = op_single(pend);
          reproc = 1'b1;
        end
      end
      MODE_INT: begin
        if (is_dotc) begin
          mode_next = MODE_INT_DOT;
        end else if (!is_dig) begin
          em_a   = 1'b1;
          kind_a = TK_INTEGER;
          reproc = 1'b1;
        end
      end
      MODE_INT_DOT, MODE_REAL: begin
        if ((mode == MODE_INT_DOT) && is_dotc) begin
          em_a      = 1'b1;
          kind_a    = TK_INTEGER;
          em_b      = 1'b1;
          kind_b    = TK_RANGE;
          mode_next = MODE_IDLE;
        end else begin
          mode_next = MODE_REAL;
          if (is_dotc) begin
            em_a      = 1'b1;
            kind_a    = TK_ERROR;
            mode_next = MODE_IDLE;
          end else if (!is_dig) begin
            em_a   = 1'b1;
            kind_a = TK_REAL;
            reproc = 1'b1;
          end
        end
      end
      MODE_IDENT: begin
        if (is_let || is_dig) begin
          cand_next = kw_step(cand, ilen, text_byte);
          if (ilen < 8'(MAX_IDENT_LEN)) begin
            ilen_next = ilen + 8'd1;
          end
        end else begin
          em_a   = 1'b1;
          kind_a = ident_kind(cand, ilen);
          reproc = 1'b1;
        end
      end
      MODE_DOT: begin
        em_a = 1'b1;
        if (is_dotc) begin
          kind_a    = TK_RANGE;
          mode_next = MODE_IDLE;
        end else begin
          kind_a = TK_DOT;
          reproc = 1'b1;
        end
      end
      default: reproc = 1'b1;
    endcase
    if (reproc) begin
      em_b      = idle_emit;
      kind_b    = idle_kind;
      mode_next = idle_mode;
      if (idle_pend_we) begin
        pend_next = idle_pend;
      end
      if (idle_ident) begin
        cand_next = kw_step({NUM_KW{1'b1}}, 8'd0, text_byte);
        ilen_next = 8'd1;
      end
    end
  end

  assign push             = accept && (em_a || em_b);
  assign push_data.two    = em_a && em_b;
  assign push_data.first  = em_a ? kind_a : kind_b;
  assign push_data.second = kind_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      cand <= {NUM_KW{1'b1}};
      ilen <= 8'd0;
      pend <= PEND_GT;
    end else if (accept) begin
      mode <= mode_next;
      cand <= cand_next;
      ilen <= ilen_next;
      pend <= pend_next;
    end
  end

endmodule

/* src/stl_queue.sv */
// ----------------------------------------------------------------------------
// stl_queue: token pair queue
// Small FIFO that decouples the byte scanner from the token emitter.
// ----------------------------------------------------------------------------
module stl_queue #(
  parameter int unsigned DEPTH = stl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  stl_pkg::tok_pair_t push_data,
  output logic               full,
  input  logic               pop,
  output stl_pkg::tok_pair_t head,
  output logic               head_valid
);
  import stl_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  tok_pair_t      mem [DEPTH];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

/* src/stl_back.sv */
// ----------------------------------------------------------------------------
// stl_back: token emitter
// Sends the tokens of each queue entry one beat at a time and marks the
// final token of every input beat.
// ----------------------------------------------------------------------------
module stl_back (
  input  logic                 clk,
  input  logic                 rst,
  input  stl_pkg::tok_pair_t   head,
  input  logic                 head_valid,
  output logic                 pop,
  output stl_pkg::token_kind_t token_kind,
  output logic                 last,
  output logic                 tok_valid,
  input  logic                 tok_ready
);
  import stl_pkg::*;

  logic second;

  assign tok_valid  = head_valid;
  assign token_kind = second ? head.second : head.first;
  assign last       = second || !head.two;
  assign pop        = tok_valid && tok_ready && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (tok_valid && tok_ready) begin
      second <= !last;
    end
  end

endmodule

/* src/source_token_lexer.sv */
// ----------------------------------------------------------------------------
// source_token_lexer: byte-serial source scanner
// Turns a stream of source bytes into token kind codes.
// ----------------------------------------------------------------------------
// Input channel (src_valid/src_ready): each beat carries one text_byte, or an
// end-of-text mark when end_of_text is high. Output channel
// (tok_valid/tok_ready): each beat carries one token_kind; last is high on
// the final token that one input beat produced. An input beat gives zero, one
// or two tokens, since the byte that ends a token is scanned again as the
// start of the next one.
// The tokens of a taken input beat are registered in the four-entry queue
// between scanner and emitter and offered from its head. Throughput: one
// input beat per cycle while the queue is not full; the scanner state
// updates on each taken beat. The output side sends one token per beat, so
// a two-token beat occupies the emitter for two output beats. The queue
// absorbs that and short receiver stalls; src_ready drops only on a full queue.
// Reset (rst, synchronous) returns the scanner to idle with an empty queue.
// While the receiver holds tok_ready low the current token stays on the port
// and scanning continues until the queue fills.
// ----------------------------------------------------------------------------
module source_token_lexer #(
  parameter int unsigned MAX_IDENT_LEN = stl_pkg::MAX_IDENT_LEN_DEF,
  parameter int unsigned QUEUE_DEPTH   = stl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 src_valid,
  output logic                 src_ready,
  input  logic [7:0]           text_byte,
  input  logic                 end_of_text,
  output logic                 tok_valid,
  input  logic                 tok_ready,
  output stl_pkg::token_kind_t token_kind,
  output logic                 last
);
  import stl_pkg::*;

  logic      accept;
  logic      push, full, pop, head_valid;
  tok_pair_t push_data, head;

  // The scanner advances on every taken beat; readiness follows queue space.
  assign src_ready = !full;
  assign accept    = src_valid && src_ready;

  stl_front #(
    .MAX_IDENT_LEN(MAX_IDENT_LEN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .text_byte  (text_byte),
    .end_of_text(end_of_text),
    .push       (push),
    .push_data  (push_data)
  );

  stl_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .head_valid(head_valid)
  );

  stl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .head_valid(head_valid),
    .pop       (pop),
    .token_kind(token_kind),
    .last      (last),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready)
  );

  // The scanner never writes into a full queue.
  assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("token pushed into full queue");

  // A beat that is not the last of its group is followed by its partner.
  assert property (@(posedge clk) disable iff (rst)
                   (tok_valid && tok_ready && !last) |=> tok_valid)
    else $error("second token of a pair missing");

  // Only defined token codes reach the output.
  assert property (@(posedge clk) disable iff (rst) tok_valid |-> (token_kind <= TK_UNKNOWN))
    else $error("token kind out of range");

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for source_token_lexer
// Drives source bytes and end-of-text beats through the input channel, keeps
// an independent scanner model that predicts the token kinds each input beat
// produces, and compares every token beat against the oldest prediction. A
// short directed table comes first, then random source text built mostly
// from well-formed tokens, with random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import stl_pkg::*;

  // Identifier length saturates at the block's default limit.
  localparam int unsigned IDENT_SAT   = MAX_IDENT_LEN_DEF;
  localparam int unsigned TEXT_ITEMS  = 1700;
  localparam int unsigned GAP_MAX     = 18;
  localparam int unsigned DRAIN_LIMIT = 4000;

  // One row of stimulus. When fixed is set, the tokens in k0/k1 (count of
  // them) are the typed-in expectation for this beat instead of the model's.
  typedef struct packed {
    logic [7:0]  ch;
    logic        eot;
    logic        fixed;
    logic [1:0]  count;
    token_kind_t k0;
    token_kind_t k1;
  } lex_row_t;

  typedef struct packed {
    token_kind_t kind;
    logic        last;
  } token_beat_t;

  logic        clk;
  logic        rst;
  logic        src_valid;
  logic        src_ready;
  logic [7:0]  text_byte;
  logic        end_of_text;
  logic        tok_valid;
  logic        tok_ready;
  token_kind_t token_kind;
  logic        last;

  // The row currently on the input port, so the checker knows whether the
  // beat carries a typed-in expectation.
  lex_row_t    cur_row;

  source_token_lexer i_dut (
    .clk         (clk),
    .rst         (rst),
    .src_valid   (src_valid),
    .src_ready   (src_ready),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .tok_valid   (tok_valid),
    .tok_ready   (tok_ready),
    .token_kind  (token_kind),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #10ms;
    $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Scanner model. Reserved words are matched with a candidate mask that is
  // narrowed one character at a time, exactly as the hardware does it, so an
  // identifier that merely starts like a keyword never matches.
  // --------------------------------------------------------------------------
  string reserved_word [NUM_KW] = '{
    "and", "or", "xor", "if", "then", "else", "true", "false",
    "var", "type", "routine", "return", "is", "in", "reverse", "for",
    "while", "loop", "end", "record", "array", "integer", "real", "boolean"
  };

  string op_text [18] = '{
    ">", ">=", "<", "<=", "=", "/=", "/", "[", "]", "(", ")",
    "+", "-", "*", "%", ",", ":", ":="
  };

  scan_mode_t        lex_mode = MODE_IDLE;
  logic [NUM_KW-1:0] kw_cand  = '1;
  logic [7:0]        id_len   = '0;
  pend_op_t          pend_op  = PEND_GT;
  token_kind_t       lex_out[$];
  token_beat_t       expected_tokens[$];
  int unsigned       mismatches = 0;
  int unsigned       beats_sent = 0;
  bit                tx_quiet = 1'b0;
  bit                rx_quiet = 1'b0;
  logic [7:0]        token_text[$];

  function automatic logic digit_ch(logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic word_ch(logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) || (b == "_");
  endfunction

  // Add one character to the identifier being scanned.
  function automatic void take_ident_char(logic [7:0] b);
    for (int k = 0; k < NUM_KW; k++) begin
      if (kw_cand[k] && (id_len >= reserved_word[k].len() || reserved_word[k][id_len] != b))
        kw_cand[k] = 1'b0;
    end
    if (id_len < IDENT_SAT) id_len = id_len + 8'd1;
  endfunction

  function automatic token_kind_t ident_code();
    for (int k = 0; k < NUM_KW; k++) begin
      if (kw_cand[k] && id_len == reserved_word[k].len())
        return TK_KEYWORD0 + token_kind_t'(k);
    end
    return TK_IDENT;
  endfunction

  function automatic token_kind_t op_code(pend_op_t p, logic with_eq);
    case (p)
      PEND_GT:    return with_eq ? TK_GE : TK_GT;
      PEND_LT:    return with_eq ? TK_LE : TK_LT;
      PEND_SLASH: return with_eq ? TK_NE : TK_SLASH;
      default:    return with_eq ? TK_ASSIGN : TK_COLON;
    endcase
  endfunction

  // Scan a beat from the idle mode. Also used for the byte that ended the
  // previous token, which is processed again.
  function automatic void start_scan(logic [7:0] b, logic eot);
    lex_mode = MODE_IDLE;
    if (eot) begin
      lex_out.push_back(TK_EOF);
    end else begin
      case (b)
        " ", "\t": ;
        "\n": lex_out.push_back(TK_NEWLINE);
        "[":  lex_out.push_back(TK_LBRACKET);
        "]":  lex_out.push_back(TK_RBRACKET);
        "(":  lex_out.push_back(TK_LPAREN);
        ")":  lex_out.push_back(TK_RPAREN);
        "=":  lex_out.push_back(TK_EQ);
        "+":  lex_out.push_back(TK_PLUS);
        "-":  lex_out.push_back(TK_MINUS);
        "*":  lex_out.push_back(TK_STAR);
        "%":  lex_out.push_back(TK_PERCENT);
        ",":  lex_out.push_back(TK_COMMA);
        ">": begin
          pend_op  = PEND_GT;
          lex_mode = MODE_OP;
        end
        "<": begin
          pend_op  = PEND_LT;
          lex_mode = MODE_OP;
        end
        "/": begin
          pend_op  = PEND_SLASH;
          lex_mode = MODE_OP;
        end
        ":": begin
          pend_op  = PEND_COLON;
          lex_mode = MODE_OP;
        end
        ".": lex_mode = MODE_DOT;
        default: begin
          if (digit_ch(b)) begin
            lex_mode = MODE_INT;
          end else if (word_ch(b)) begin
            lex_mode = MODE_IDENT;
            id_len   = '0;
            kw_cand  = '1;
            take_ident_char(b);
          end else begin
            lex_out.push_back(TK_UNKNOWN);
          end
        end
      endcase
    end
  endfunction

  // Fraction digits of a real. A second dot is an error and is swallowed.
  function automatic void real_tail(logic [7:0] b, logic eot);
    if (!eot && digit_ch(b)) begin
    end else if (!eot && b == ".") begin
      lex_mode = MODE_IDLE;
      lex_out.push_back(TK_ERROR);
    end else begin
      lex_out.push_back(TK_REAL);
      start_scan(b, eot);
    end
  endfunction

  // Advance the model by one input beat; the tokens land in lex_out.
  function automatic void lex_step(logic [7:0] b, logic eot);
    lex_out.delete();
    case (lex_mode)
      MODE_OP: begin
        if (!eot && b == "=") begin
          lex_mode = MODE_IDLE;
          lex_out.push_back(op_code(pend_op, 1'b1));
        end else begin
          lex_out.push_back(op_code(pend_op, 1'b0));
          start_scan(b, eot);
        end
      end
      MODE_INT: begin
        if (!eot && digit_ch(b)) begin
        end else if (!eot && b == ".") begin
          lex_mode = MODE_INT_DOT;
        end else begin
          lex_out.push_back(TK_INTEGER);
          start_scan(b, eot);
        end
      end
      MODE_INT_DOT: begin
        // Digits followed by two dots: an integer, then a range.
        if (!eot && b == ".") begin
          lex_mode = MODE_IDLE;
          lex_out.push_back(TK_INTEGER);
          lex_out.push_back(TK_RANGE);
        end else begin
          lex_mode = MODE_REAL;
          real_tail(b, eot);
        end
      end
      MODE_REAL: real_tail(b, eot);
      MODE_IDENT: begin
        if (!eot && (word_ch(b) || digit_ch(b))) begin
          take_ident_char(b);
        end else begin
          lex_out.push_back(ident_code());
          start_scan(b, eot);
        end
      end
      MODE_DOT: begin
        if (!eot && b == ".") begin
          lex_mode = MODE_IDLE;
          lex_out.push_back(TK_RANGE);
        end else begin
          lex_out.push_back(TK_DOT);
          start_scan(b, eot);
        end
      end
      default: start_scan(b, eot);
    endcase
  endfunction

  function automatic void flag_mismatch(string what, string want, string got);
    mismatches++;
    $display("%0t: %s mismatch: expected %s, actual %s", $time, what, want, got);
  endfunction

  // --------------------------------------------------------------------------
  // Checker. Input beats are turned into predictions and token beats are
  // compared in the same clocked process, using the values sampled just
  // before the edge, so the outcome never depends on process order.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : tok_check
    token_beat_t want;
    if (rst) begin
      lex_mode = MODE_IDLE;
      kw_cand  = '1;
      id_len   = '0;
      pend_op  = PEND_GT;
      expected_tokens.delete();
    end else begin
      if (src_valid && src_ready) begin
        lex_step(text_byte, end_of_text);
        if (cur_row.fixed) begin
          // The model still advances, but the typed-in tokens are expected.
          lex_out.delete();
          if (cur_row.count > 2'd0) lex_out.push_back(cur_row.k0);
          if (cur_row.count > 2'd1) lex_out.push_back(cur_row.k1);
        end
        foreach (lex_out[i]) begin
          want.kind = lex_out[i];
          want.last = (i == lex_out.size() - 1);
          expected_tokens.push_back(want);
        end
      end
      if (tok_valid && tok_ready) begin
        if (expected_tokens.size() == 0) begin
          flag_mismatch("token beat", "none",
                        $sformatf("kind %0d last %0d", token_kind, last));
        end else begin
          want = expected_tokens.pop_front();
          if (token_kind !== want.kind)
            flag_mismatch("token_kind", $sformatf("%0d", want.kind),
                          $sformatf("%0d", token_kind));
          if (last !== want.last)
            flag_mismatch("last", $sformatf("%0d", want.last), $sformatf("%0d", last));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: draws a stall before every token beat; now and then switches
  // into a stretch where it never stalls.
  // --------------------------------------------------------------------------
  initial begin : token_sink
    int unsigned stall;
    tok_ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) rx_quiet = !rx_quiet;
      stall = rx_quiet ? 0 : $urandom_range(0, GAP_MAX);
      if (stall != 0) begin
        tok_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      tok_ready <= 1'b1;
      do @(posedge clk); while (!tok_valid);
    end
  end

  // --------------------------------------------------------------------------
  // Sender helpers
  // --------------------------------------------------------------------------
  function automatic lex_row_t text_row(logic [7:0] ch, logic eot);
    lex_row_t r;
    r       = '0;
    r.ch    = ch;
    r.eot   = eot;
    return r;
  endfunction

  function automatic lex_row_t fixed_row(logic [7:0] ch, logic eot, logic [1:0] count,
                                         token_kind_t k0, token_kind_t k1);
    lex_row_t r;
    r.ch    = ch;
    r.eot   = eot;
    r.fixed = 1'b1;
    r.count = count;
    r.k0    = k0;
    r.k1    = k1;
    return r;
  endfunction

  // Present one input beat after a random gap and hold it until it is taken.
  // Valid is either kept high with a new payload or lowered, never both in
  // one step.
  task automatic send_beat(lex_row_t r);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_valid   <= 1'b1;
    text_byte   <= r.ch;
    end_of_text <= r.eot;
    cur_row     <= r;
    do @(posedge clk); while (!src_ready);
    beats_sent++;
  endtask

  function automatic logic [7:0] rand_letter();
    case ($urandom_range(0, 4))
      0:       return "_";
      1:       return 8'("A" + $urandom_range(0, 25));
      default: return 8'("a" + $urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] rand_name_ch();
    return ($urandom_range(0, 3) == 0) ? 8'("0" + $urandom_range(0, 9)) : rand_letter();
  endfunction

  function automatic void add_digits(int unsigned n);
    repeat (n) token_text.push_back(8'("0" + $urandom_range(0, 9)));
  endfunction

  function automatic void add_name(int unsigned n);
    token_text.push_back(rand_letter());
    repeat (n - 1) token_text.push_back(rand_name_ch());
  endfunction

  // Build one random token (or a bit of noise) and send it, followed by an
  // optional separator. Adjacent tokens without a separator exercise the
  // case where the byte that ends a token starts the next one.
  task automatic send_random_token(bit long_name);
    int unsigned pick;
    int unsigned k;
    logic [7:0]  odd_bytes [8];
    odd_bytes = '{8'h0D, 8'hFF, 8'h00, "!", "#", "\\", 8'h80, 8'h7F};
    token_text.delete();
    pick = $urandom_range(0, 99);
    if (long_name) begin
      // Past the saturation point of the length counter.
      add_name($urandom_range(IDENT_SAT + 1, IDENT_SAT + 45));
    end else if (pick < 18) begin
      k = $urandom_range(0, NUM_KW - 1);
      for (int i = 0; i < reserved_word[k].len(); i++)
        token_text.push_back(reserved_word[k][i]);
      case ($urandom_range(0, 9))
        0: token_text[0] = token_text[0] - 8'h20;      // capitalized: no keyword
        1: token_text.push_back(rand_name_ch());      // longer than the keyword
        2: token_text.delete(token_text.size() - 1);  // a prefix only
        default: ;
      endcase
    end else if (pick < 30) begin
      add_name($urandom_range(1, 12));
    end else if (pick < 40) begin
      add_digits($urandom_range(1, 5));
    end else if (pick < 46) begin
      add_digits($urandom_range(1, 3));
      token_text.push_back(".");
      add_digits($urandom_range(0, 4));
    end else if (pick < 50) begin
      if ($urandom_range(0, 1)) add_digits($urandom_range(1, 3));
      token_text.push_back(".");
      token_text.push_back(".");
      if ($urandom_range(0, 1)) add_digits($urandom_range(1, 3));
    end else if (pick < 52) begin
      // A real with a second dot.
      add_digits($urandom_range(1, 2));
      token_text.push_back(".");
      add_digits($urandom_range(1, 2));
      token_text.push_back(".");
    end else if (pick < 54) begin
      token_text.push_back(".");
    end else if (pick < 70) begin
      k = $urandom_range(0, 17);
      for (int i = 0; i < op_text[k].len(); i++)
        token_text.push_back(op_text[k][i]);
    end else if (pick < 80) begin
      case ($urandom_range(0, 2))
        0:       token_text.push_back("\n");
        1:       token_text.push_back(" ");
        default: token_text.push_back("\t");
      endcase
    end else if (pick < 85) begin
      // End of text; the byte on the port is don't-care.
      send_beat(text_row(8'($urandom_range(0, 255)), 1'b1));
      return;
    end else if (pick < 93) begin
      token_text.push_back(8'($urandom_range(0, 255)));
    end else begin
      token_text.push_back(odd_bytes[$urandom_range(0, 7)]);
    end
    foreach (token_text[i]) send_beat(text_row(token_text[i], 1'b0));
    case ($urandom_range(0, 9))
      5, 6, 7: send_beat(text_row(" ", 1'b0));
      8:       send_beat(text_row("\t", 1'b0));
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    lex_row_t    dir_tab[$];
    int unsigned tokens_made;
    int unsigned drain;
    src_valid   <= 1'b0;
    text_byte   <= 8'h00;
    end_of_text <= 1'b0;
    cur_row     <= '0;
    rst         <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part: control characters and unknown bytes, several number
    // corners, a two-character operator, and end of text inside tokens.
    dir_tab = '{
      fixed_row("\n",  1'b0, 2'd1, TK_NEWLINE, TK_NEWLINE),
      fixed_row(8'hFF, 1'b0, 2'd1, TK_UNKNOWN, TK_UNKNOWN),
      fixed_row(8'h0D, 1'b0, 2'd1, TK_UNKNOWN, TK_UNKNOWN),
      fixed_row(8'h00, 1'b0, 2'd1, TK_UNKNOWN, TK_UNKNOWN),
      fixed_row("-",   1'b0, 2'd1, TK_MINUS,   TK_MINUS),
      text_row("1", 1'b0),
      text_row(".", 1'b0),
      fixed_row(".",   1'b0, 2'd2, TK_INTEGER, TK_RANGE),
      text_row("2", 1'b0),
      text_row(".", 1'b0),
      fixed_row("x",   1'b0, 2'd1, TK_REAL,    TK_REAL),
      fixed_row(" ",   1'b0, 2'd1, TK_IDENT,   TK_IDENT),
      text_row("3", 1'b0),
      text_row(".", 1'b0),
      text_row("5", 1'b0),
      fixed_row(".",   1'b0, 2'd1, TK_ERROR,   TK_ERROR),
      text_row(">", 1'b0),
      fixed_row("=",   1'b0, 2'd1, TK_GE,      TK_GE),
      text_row(":", 1'b0),
      fixed_row(8'hFF, 1'b1, 2'd2, TK_COLON,   TK_EOF),
      text_row("9", 1'b0),
      text_row(".", 1'b0),
      fixed_row(8'h00, 1'b1, 2'd2, TK_REAL,    TK_EOF),
      fixed_row(8'hA5, 1'b1, 2'd1, TK_EOF,     TK_EOF)
    };
    foreach (dir_tab[i]) send_beat(dir_tab[i]);

    // Let the output side run dry before the random part starts.
    src_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);

    tokens_made = 0;
    while (beats_sent < TEXT_ITEMS) begin
      if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
      send_random_token(tokens_made == 3);
      tokens_made++;
      if (tokens_made == 400) begin
        src_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge clk);
      end
    end
    src_valid <= 1'b0;

    // Drain, then give any stray token a chance to show up.
    drain = 0;
    while (expected_tokens.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    if (expected_tokens.size() != 0)
      flag_mismatch("outstanding tokens", "0", $sformatf("%0d", expected_tokens.size()));

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
src/stl_pkg.sv
src/stl_front.sv
src/stl_queue.sv
src/stl_back.sv
src/source_token_lexer.sv
verif/testbench.sv
